### rtl/tsut_pkg.sv
// Package for the time-sorted unique-id table: field widths, codes,
// record layout and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package tsut_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);

  localparam int ID_W     = 32;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int STATUS_W = 3;

  // Validity limits for an inserted record
  localparam logic [MONTH_W-1:0]  MONTH_MAX  = MONTH_W'(12);
  localparam logic [DAY_W-1:0]    DAY_MAX    = DAY_W'(31);
  localparam logic [HOUR_W-1:0]   HOUR_MAX   = HOUR_W'(24);
  localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(60);

  typedef enum logic [1:0] {
    MODE_INSERT,
    MODE_SEARCH,
    MODE_DELETE,
    MODE_LIST
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_DUP,
    ST_NOTFOUND,
    ST_FULL,
    ST_BADDATE,
    ST_BADTIME,
    ST_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MOVE,
    S_PLACE,
    S_LIST,
    S_EMIT
  } state_t;

  // One stored record; hour and minute together give the sort key
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } rec_t;

  typedef struct packed {
    logic    idle;        // ready for a new request
    logic    scan_start;  // clear walk index and scan results
    logic    scan;        // walk entries, compare ids and times
    logic    move_start;  // load walk index for the shift
    logic    move;        // shift entries up (insert) or down (delete)
    logic    place;       // write new record, bump occupancy
    logic    shrink;      // drop occupancy by one
    logic    list;        // stream all entries to the output
    logic    emit;        // send one single result
    logic    show;        // single result carries the found record
    status_t code;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  accepted;
    logic  full;
    logic  empty;
    logic  hit;
    logic  bad_date;
    logic  bad_time;
    logic  scan_done;
    logic  move_done;
    logic  list_done;
    logic  out_ok;
  } sts_t;

endpackage

### rtl/tsut_if.sv
// Valid/ready channel interfaces for requests and results of the table.
// Depends on tsut_pkg.
`timescale 1ns / 1ps

interface tsut_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [tsut_pkg::ID_W-1:0]     visitor_id;
  logic [tsut_pkg::YEAR_W-1:0]   year;
  logic [tsut_pkg::MONTH_W-1:0]  month;
  logic [tsut_pkg::DAY_W-1:0]    day_of_month;
  logic [tsut_pkg::HOUR_W-1:0]   hour;
  logic [tsut_pkg::MINUTE_W-1:0] minute;

  modport source (output valid, mode, visitor_id, year, month, day_of_month, hour, minute,
                  input ready);
  modport sink (input valid, mode, visitor_id, year, month, day_of_month, hour, minute,
                output ready);
endinterface

interface tsut_out_if #(parameter int CNT_W = tsut_pkg::CNT_W_DEFAULT);
  logic                          valid;
  logic                          ready;
  logic [tsut_pkg::STATUS_W-1:0] status;
  logic [tsut_pkg::ID_W-1:0]     found_id;
  logic [tsut_pkg::YEAR_W-1:0]   found_year;
  logic [tsut_pkg::MONTH_W-1:0]  found_month;
  logic [tsut_pkg::DAY_W-1:0]    found_day;
  logic [tsut_pkg::HOUR_W-1:0]   found_hour;
  logic [tsut_pkg::MINUTE_W-1:0] found_minute;
  logic [CNT_W-1:0]              entry_count;
  logic                          last;

  modport source (output valid, status, found_id, found_year, found_month, found_day,
                  found_hour, found_minute, entry_count, last, input ready);
  modport sink (input valid, status, found_id, found_year, found_month, found_day,
                found_hour, found_minute, entry_count, last, output ready);
endinterface

### rtl/tsut_ctrl.sv
// Controller state machine: sequences scan, shift, place, list and emit phases.
// Depends on tsut_pkg; drives the datapath only through cmd_t/sts_t.
`timescale 1ns / 1ps

module tsut_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  tsut_pkg::sts_t  sts,
  output tsut_pkg::cmd_t  cmd
);

  tsut_pkg::state_t  state, state_next;
  tsut_pkg::status_t code, code_next;

  // Hold state and pending result code
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsut_pkg::S_IDLE;
      code  <= tsut_pkg::ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    code_next  = code;
    case (state)
      tsut_pkg::S_IDLE: begin
        if (sts.accepted) state_next = tsut_pkg::S_CHECK;
      end
      tsut_pkg::S_CHECK: begin
        case (sts.mode)
          tsut_pkg::MODE_INSERT: begin
            if (sts.full) begin
              code_next  = tsut_pkg::ST_FULL;
              state_next = tsut_pkg::S_EMIT;
            end else begin
              state_next = tsut_pkg::S_SCAN;
            end
          end
          tsut_pkg::MODE_LIST: begin
            if (sts.empty) begin
              code_next  = tsut_pkg::ST_EMPTY;
              state_next = tsut_pkg::S_EMIT;
            end else begin
              state_next = tsut_pkg::S_LIST;
            end
          end
          default: begin
            if (sts.empty) begin
              code_next  = tsut_pkg::ST_EMPTY;
              state_next = tsut_pkg::S_EMIT;
            end else begin
              state_next = tsut_pkg::S_SCAN;
            end
          end
        endcase
      end
      tsut_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          case (sts.mode)
            tsut_pkg::MODE_INSERT: begin
              state_next = tsut_pkg::S_EMIT;
              if (sts.hit) begin
                code_next = tsut_pkg::ST_DUP;
              end else if (sts.bad_date) begin
                code_next = tsut_pkg::ST_BADDATE;
              end else if (sts.bad_time) begin
                code_next = tsut_pkg::ST_BADTIME;
              end else begin
                state_next = tsut_pkg::S_MOVE;
              end
            end
            tsut_pkg::MODE_DELETE: begin
              if (sts.hit) begin
                state_next = tsut_pkg::S_MOVE;
              end else begin
                code_next  = tsut_pkg::ST_NOTFOUND;
                state_next = tsut_pkg::S_EMIT;
              end
            end
            default: begin
              code_next  = sts.hit ? tsut_pkg::ST_OK : tsut_pkg::ST_NOTFOUND;
              state_next = tsut_pkg::S_EMIT;
            end
          endcase
        end
      end
      tsut_pkg::S_MOVE: begin
        if (sts.move_done) begin
          if (sts.mode == tsut_pkg::MODE_INSERT) begin
            state_next = tsut_pkg::S_PLACE;
          end else begin
            code_next  = tsut_pkg::ST_OK;
            state_next = tsut_pkg::S_EMIT;
          end
        end
      end
      tsut_pkg::S_PLACE: begin
        code_next  = tsut_pkg::ST_OK;
        state_next = tsut_pkg::S_EMIT;
      end
      tsut_pkg::S_LIST: begin
        if (sts.list_done) state_next = tsut_pkg::S_IDLE;
      end
      tsut_pkg::S_EMIT: begin
        if (sts.out_ok) state_next = tsut_pkg::S_IDLE;
      end
      default: begin
        state_next = tsut_pkg::S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.code = code;
    cmd.show = (code == tsut_pkg::ST_OK) && (sts.mode == tsut_pkg::MODE_SEARCH);
    case (state)
      tsut_pkg::S_IDLE:  cmd.idle = 1'b1;
      tsut_pkg::S_CHECK: cmd.scan_start = 1'b1;
      tsut_pkg::S_SCAN: begin
        cmd.scan       = 1'b1;
        cmd.move_start = sts.scan_done;
      end
      tsut_pkg::S_MOVE: begin
        cmd.move   = 1'b1;
        cmd.shrink = sts.move_done && (sts.mode == tsut_pkg::MODE_DELETE);
      end
      tsut_pkg::S_PLACE: cmd.place = 1'b1;
      tsut_pkg::S_LIST:  cmd.list = 1'b1;
      tsut_pkg::S_EMIT:  cmd.emit = 1'b1;
      default: cmd.idle = 1'b0;
    endcase
  end

endmodule

### rtl/tsut_dp.sv
// Datapath: record memory, walk counters, id/time compare, occupancy and
// output register. Depends on tsut_pkg and the channel interfaces in tsut_if.
`timescale 1ns / 1ps

module tsut_dp #(
  parameter int TABLE_DEPTH = tsut_pkg::DEPTH_DEFAULT,
  parameter int CNT_W       = tsut_pkg::CNT_W_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  tsut_in_if.sink        item,
  tsut_out_if.source     result,
  input  tsut_pkg::cmd_t cmd,
  output tsut_pkg::sts_t sts
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef struct packed {
    tsut_pkg::status_t status;
    tsut_pkg::rec_t    rec;
    logic [CNT_W-1:0]  count;
    logic              last;
  } res_t;

  tsut_pkg::rec_t mem [TABLE_DEPTH];

  // Latched request
  tsut_pkg::mode_t mode;
  tsut_pkg::rec_t  new_rec;

  // Walk and scan state
  logic [CNT_W-1:0] occ, occ_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] le_cnt, le_cnt_next;
  logic             hit, hit_next;
  logic [IW-1:0]    hit_idx, hit_idx_next;
  tsut_pkg::rec_t   hit_rec, hit_rec_next;
  tsut_pkg::rec_t   rd_data;
  logic             rd_vld, rd_vld_next;
  logic [IW-1:0]    rd_idx;

  // Output register
  logic out_vld, out_vld_next;
  res_t out_q, out_d;

  logic             insert_mode;
  logic             scan_issue, up_issue, dn_issue, list_issue, issue;
  logic             list_load, out_ok, out_load;
  logic [CNT_W-1:0] idx_dec, idx_inc;
  logic [IW-1:0]    rd_addr, wr_addr;
  logic             wr_en;
  tsut_pkg::rec_t   wr_data;
  logic             id_match, time_le;

  assign insert_mode = (mode == tsut_pkg::MODE_INSERT);
  assign idx_dec     = idx - CNT_W'(1);
  assign idx_inc     = idx + CNT_W'(1);

  // Read issue per phase
  assign out_ok     = !out_vld || result.ready;
  assign list_load  = cmd.list && rd_vld && out_ok;
  assign scan_issue = cmd.scan && (idx < occ) && !hit;
  assign up_issue   = cmd.move && insert_mode && (idx > le_cnt);
  assign dn_issue   = cmd.move && !insert_mode && (idx < occ);
  assign list_issue = cmd.list && (idx < occ) && (!rd_vld || list_load);
  assign issue      = scan_issue || up_issue || dn_issue || list_issue;
  assign rd_addr    = up_issue ? idx_dec[IW-1:0] : idx[IW-1:0];

  // Compare returned entry against the request
  assign id_match = rd_data.id == new_rec.id;
  assign time_le  = {rd_data.hour, rd_data.minute} <= {new_rec.hour, new_rec.minute};

  // Write port: shifted entry or the new record
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = le_cnt[IW-1:0];
    wr_data = new_rec;
    if (cmd.move && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = insert_mode ? (rd_idx + IW'(1)) : (rd_idx - IW'(1));
      wr_data = rd_data;
    end else if (cmd.place) begin
      wr_en = 1'b1;
    end
  end

  // Record memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) begin
      rd_data <= mem[rd_addr];
      rd_idx  <= rd_addr;
    end
  end

  // Latch request payload on accept
  always_ff @(posedge clk) begin
    if (sts.accepted) begin
      mode           <= tsut_pkg::mode_t'(item.mode);
      new_rec.id     <= item.visitor_id;
      new_rec.year   <= item.year;
      new_rec.month  <= item.month;
      new_rec.day    <= item.day_of_month;
      new_rec.hour   <= item.hour;
      new_rec.minute <= item.minute;
    end
  end

  // Walk counters and scan results
  always_comb begin
    idx_next     = idx;
    le_cnt_next  = le_cnt;
    hit_next     = hit;
    hit_idx_next = hit_idx;
    hit_rec_next = hit_rec;
    rd_vld_next  = issue || (rd_vld && cmd.list && !list_load);
    occ_next     = occ;
    if (cmd.scan_start) begin
      idx_next    = '0;
      le_cnt_next = '0;
      hit_next    = 1'b0;
      rd_vld_next = 1'b0;
    end else if (cmd.move_start) begin
      idx_next = insert_mode ? occ : (CNT_W'(hit_idx) + CNT_W'(1));
    end else if (issue) begin
      idx_next = up_issue ? idx_dec : idx_inc;
    end
    if (cmd.scan && rd_vld) begin
      if (id_match && !hit) begin
        hit_next     = 1'b1;
        hit_idx_next = rd_idx;
        hit_rec_next = rd_data;
      end
      if (time_le) le_cnt_next = le_cnt + CNT_W'(1);
    end
    if (cmd.place) occ_next = occ + CNT_W'(1);
    else if (cmd.shrink) occ_next = occ - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      rd_vld <= 1'b0;
      hit    <= 1'b0;
    end else begin
      occ    <= occ_next;
      rd_vld <= rd_vld_next;
      hit    <= hit_next;
    end
    idx     <= idx_next;
    le_cnt  <= le_cnt_next;
    hit_idx <= hit_idx_next;
    hit_rec <= hit_rec_next;
  end

  // Output register: single result or one listed entry
  assign out_load = (cmd.emit && out_ok) || list_load;

  always_comb begin
    out_d.count = occ;
    if (cmd.list) begin
      out_d.status = tsut_pkg::ST_OK;
      out_d.rec    = rd_data;
      out_d.last   = (CNT_W'(rd_idx) + CNT_W'(1)) == occ;
    end else begin
      out_d.status = cmd.code;
      out_d.rec    = cmd.show ? hit_rec : '0;
      out_d.last   = 1'b1;
    end
    out_vld_next = out_load ? 1'b1 : (result.ready ? 1'b0 : out_vld);
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= out_vld_next;
    if (out_load) out_q <= out_d;
  end

  assign item.ready          = cmd.idle;
  assign result.valid        = out_vld;
  assign result.status       = out_q.status;
  assign result.found_id     = out_q.rec.id;
  assign result.found_year   = out_q.rec.year;
  assign result.found_month  = out_q.rec.month;
  assign result.found_day    = out_q.rec.day;
  assign result.found_hour   = out_q.rec.hour;
  assign result.found_minute = out_q.rec.minute;
  assign result.entry_count  = out_q.count;
  assign result.last         = out_q.last;

  // Status to the controller
  always_comb begin
    sts.mode      = mode;
    sts.accepted  = item.valid && cmd.idle;
    sts.full      = occ == CNT_W'(TABLE_DEPTH);
    sts.empty     = occ == '0;
    sts.hit       = hit;
    sts.bad_date  = (new_rec.month > tsut_pkg::MONTH_MAX) || (new_rec.day > tsut_pkg::DAY_MAX);
    sts.bad_time  = (new_rec.hour > tsut_pkg::HOUR_MAX) ||
                    (new_rec.minute > tsut_pkg::MINUTE_MAX);
    sts.scan_done = !rd_vld && ((idx == occ) || hit);
    sts.move_done = !rd_vld && (insert_mode ? (idx == le_cnt) : (idx == occ));
    sts.list_done = !rd_vld && (idx == occ);
    sts.out_ok    = out_ok;
  end

endmodule

### rtl/time_sorted_unique_id_table.sv
// Time-sorted unique-id table. One request at a time; a request that walks the record memory
// reads one entry per cycle (a list pauses while the output stalls), and the next request is
// taken once the controller is idle again. An insert into a full table, or any other request
// on an empty table, is answered without a walk; a list gives one result per cycle while the
// output drains.
// Synchronous reset empties the table; memory contents are not cleared.
`timescale 1ns / 1ps

module time_sorted_unique_id_table #(
  parameter int TABLE_DEPTH = tsut_pkg::DEPTH_DEFAULT,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst,
  tsut_in_if.sink    item,
  tsut_out_if.source result
);

  tsut_pkg::cmd_t cmd;
  tsut_pkg::sts_t sts;

  // Sequence phases
  tsut_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Store, compare and emit
  tsut_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
